FILE: hw/rtl/buddy_page_allocator_unit_defines.svh
// assertion macros shared by the buddy page allocator rtl
// depends on clk_i and rst_ni being visible in the module that uses them
`ifndef BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_UNIT_DEFINES_SVH

// property must hold at every clock edge outside reset
`define BPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bpa assertion failed");

// condition must never be true outside reset
`define BPA_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("bpa forbidden condition seen");

`endif

FILE: hw/rtl/bpa_pkg.sv
// types, constants and helper functions of the buddy page allocator
// no dependencies
package bpa_pkg;

  localparam int PAGE_COUNT_LOG2_DEF = 16;
  localparam int LEVEL_W  = 5;
  localparam int SIZE_W   = 20;
  localparam int PAGE_W   = 16;
  localparam int STATUS_W = 2;

  localparam logic [LEVEL_W-1:0] MARK_MERGED = 5'd30;
  localparam logic [LEVEL_W-1:0] MARK_ALLOC  = 5'd31;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_ALLOC = 2'd2;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_SRCH, CMD_FAIL,
    CMD_S_SET, CMD_U_RD, CMD_U_WR, CMD_S_MA, CMD_S_MB,
    CMD_P_WR1, CMD_P_WR2, CMD_S_PA, CMD_G_SET, CMD_G_MK,
    CMD_F_RD, CMD_F_CHK, CMD_M_RD, CMD_M_CMP, CMD_M_HI,
    CMD_M_MKLO, CMD_M_MKHI
  } cmd_e;

  typedef enum logic [5:0] {
    S_CLEAR, S_IDLE, S_DEC, S_SRCH, S_FAIL,
    S_S_SET, S_S_URD, S_S_UWR, S_S_MA, S_S_MB, S_S_PB1, S_S_PB2,
    S_S_PA, S_S_PA1, S_S_PA2,
    S_G_SET, S_G_URD, S_G_UWR, S_G_MK,
    S_F_RD, S_F_CHK, S_F_P1, S_F_P2,
    S_M_CHK, S_M_RD, S_M_CMP, S_M_LURD, S_M_LUWR, S_M_HI, S_M_HURD, S_M_HUWR,
    S_M_MKLO, S_M_MKHI, S_M_P1, S_M_P2,
    S_RESP
  } state_e;

  typedef struct packed {
    logic clr_last;
    logic is_free_op;
    logic too_big;
    logic found;
    logic lvl_over;
    logic lvl_gt_want;
    logic is_alloc;
    logic lvl_top;
    logic bud_free;
  } dp_stat_t;

  // level k such that 4 KB * 2^k is the smallest block holding size kilobytes
  function automatic logic [LEVEL_W-1:0] want_level(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0]  m;
    logic [LEVEL_W-1:0] len;
    m   = size - SIZE_W'(1);
    len = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (m[i]) len = LEVEL_W'(i + 1);
    end
    if (size <= SIZE_W'(4)) return '0;
    return len - LEVEL_W'(2);
  endfunction

endpackage

FILE: hw/rtl/bpa_ram.sv
// generic single port ram with registered read
// no dependencies
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

FILE: hw/rtl/bpa_dp.sv
// datapath: page mark, block order and link memories, list heads, work registers
// depends on bpa_pkg and bpa_ram
module bpa_dp #(
  parameter int PAGE_COUNT_LOG2 = bpa_pkg::PAGE_COUNT_LOG2_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  bpa_pkg::cmd_e                   cmd_i,
  input  logic                            op_i,
  input  logic [bpa_pkg::SIZE_W-1:0]      size_kb_i,
  input  logic [bpa_pkg::PAGE_W-1:0]      page_index_i,
  output bpa_pkg::dp_stat_t               stat_o,
  output logic [bpa_pkg::STATUS_W-1:0]    status_o,
  output logic [bpa_pkg::PAGE_W-1:0]      granted_page_o,
  output logic [bpa_pkg::LEVEL_W-1:0]     granted_level_o
);
  localparam int PW     = PAGE_COUNT_LOG2;
  localparam int LW     = PW + 1;
  localparam int LEVELS = PW + 1;
  localparam int LIW    = $clog2(LEVELS);
  localparam int DEPTH  = 2 ** PW;
  localparam int VW     = bpa_pkg::LEVEL_W;
  localparam logic [LW-1:0] NIL = {1'b1, {PW{1'b0}}};
  localparam logic [VW-1:0] TOP = VW'(PW);

  logic [LW-1:0] heads_q [LEVELS];
  logic [PW-1:0] clr_cnt_q;
  logic          op_q;
  logic [VW-1:0] want_q, lvl_q, u_l_q;
  logic [PW-1:0] pg_q, a_q, b_q, u_p_q;
  logic [LW-1:0] h_q;
  logic [bpa_pkg::STATUS_W-1:0] res_status_q;
  logic [PW-1:0] res_page_q;
  logic [VW-1:0] res_level_q;

  logic          mark_we, order_we, next_we, prev_we;
  logic [PW-1:0] mark_addr, order_addr, next_addr, prev_addr;
  logic [VW-1:0] mark_wd, order_wd, mark_rd, order_rd;
  logic [LW-1:0] next_wd, prev_wd, next_rd, prev_rd;

  logic [LW-1:0] head_lvl, head_ul, head_want;
  logic [VW-1:0] lvl_m1, lvl_p1, flvl;
  logic [PW-1:0] bit_lvl, bit_m1, lo_pg, hi_pg;
  logic          is_alloc;

  assign head_lvl  = (lvl_q <= TOP) ? heads_q[lvl_q[LIW-1:0]] : NIL;
  assign head_ul   = heads_q[u_l_q[LIW-1:0]];
  assign head_want = heads_q[want_q[LIW-1:0]];
  assign lvl_m1    = lvl_q - VW'(1);
  assign lvl_p1    = lvl_q + VW'(1);
  assign bit_lvl   = PW'(1) << lvl_q;
  assign bit_m1    = PW'(1) << lvl_m1;
  assign lo_pg     = pg_q & ~bit_lvl;
  assign hi_pg     = pg_q | bit_lvl;
  assign is_alloc  = (mark_rd == bpa_pkg::MARK_ALLOC);
  assign flvl      = (order_rd > TOP) ? TOP : order_rd;

  always_comb begin
    stat_o.clr_last    = &clr_cnt_q;
    stat_o.is_free_op  = op_q;
    stat_o.too_big     = want_q > TOP;
    stat_o.found       = head_lvl != NIL;
    stat_o.lvl_over    = lvl_q > TOP;
    stat_o.lvl_gt_want = lvl_q > want_q;
    stat_o.is_alloc    = is_alloc;
    stat_o.lvl_top     = lvl_q >= TOP;
    stat_o.bud_free    = mark_rd == lvl_q;
  end

  // memory port selection
  always_comb begin
    mark_we = 1'b0;  mark_addr = pg_q;  mark_wd = '0;
    order_we = 1'b0; order_addr = pg_q; order_wd = '0;
    next_we = 1'b0;  next_addr = u_p_q; next_wd = '0;
    prev_we = 1'b0;  prev_addr = u_p_q; prev_wd = '0;
    case (cmd_i)
      bpa_pkg::CMD_CLEAR: begin
        mark_we    = 1'b1;
        mark_addr  = clr_cnt_q;
        mark_wd    = (clr_cnt_q == '0) ? TOP : bpa_pkg::MARK_MERGED;
        order_we   = 1'b1;
        order_addr = clr_cnt_q;
        order_wd   = (clr_cnt_q == '0) ? TOP : '0;
        // page 0 starts as the only entry of the top list, so its links end there
        next_we    = 1'b1;
        next_addr  = clr_cnt_q;
        next_wd    = NIL;
        prev_we    = 1'b1;
        prev_addr  = clr_cnt_q;
        prev_wd    = NIL;
      end
      bpa_pkg::CMD_U_WR: begin
        next_we   = prev_rd != NIL;
        next_addr = prev_rd[PW-1:0];
        next_wd   = next_rd;
        prev_we   = next_rd != NIL;
        prev_addr = next_rd[PW-1:0];
        prev_wd   = prev_rd;
      end
      bpa_pkg::CMD_P_WR1: begin
        next_we = 1'b1;
        next_wd = head_ul;
        prev_we = 1'b1;
        prev_wd = NIL;
      end
      bpa_pkg::CMD_P_WR2: begin
        prev_we   = h_q != NIL;
        prev_addr = h_q[PW-1:0];
        prev_wd   = {1'b0, u_p_q};
      end
      bpa_pkg::CMD_S_MA: begin
        mark_we = 1'b1;  mark_addr = a_q;  mark_wd = lvl_m1;
        order_we = 1'b1; order_addr = a_q; order_wd = lvl_m1;
      end
      bpa_pkg::CMD_S_MB: begin
        mark_we = 1'b1;  mark_addr = b_q;  mark_wd = lvl_m1;
        order_we = 1'b1; order_addr = b_q; order_wd = lvl_m1;
      end
      bpa_pkg::CMD_G_MK: begin
        mark_we = 1'b1; mark_addr = u_p_q; mark_wd = bpa_pkg::MARK_ALLOC;
      end
      bpa_pkg::CMD_F_CHK: begin
        mark_we = is_alloc; mark_wd = flvl;
      end
      bpa_pkg::CMD_M_RD: begin
        mark_addr = pg_q ^ bit_lvl;
      end
      bpa_pkg::CMD_M_MKLO: begin
        mark_we = 1'b1;  mark_addr = lo_pg;  mark_wd = lvl_p1;
        order_we = 1'b1; order_addr = lo_pg; order_wd = lvl_p1;
      end
      bpa_pkg::CMD_M_MKHI: begin
        mark_we = 1'b1; mark_addr = hi_pg; mark_wd = bpa_pkg::MARK_MERGED;
      end
      default: ;
    endcase
  end

  bpa_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_mark_ram (
    .clk_i, .we_i(mark_we), .addr_i(mark_addr), .wdata_i(mark_wd), .rdata_o(mark_rd));
  bpa_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_order_ram (
    .clk_i, .we_i(order_we), .addr_i(order_addr), .wdata_i(order_wd), .rdata_o(order_rd));
  bpa_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_next_ram (
    .clk_i, .we_i(next_we), .addr_i(next_addr), .wdata_i(next_wd), .rdata_o(next_rd));
  bpa_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_prev_ram (
    .clk_i, .we_i(prev_we), .addr_i(prev_addr), .wdata_i(prev_wd), .rdata_o(prev_rd));

  // list heads and clear counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) heads_q[i] <= (i == PW) ? '0 : NIL;
      clr_cnt_q   <= '0;
    end else begin
      if (cmd_i == bpa_pkg::CMD_CLEAR) clr_cnt_q <= clr_cnt_q + PW'(1);
      if (cmd_i == bpa_pkg::CMD_U_WR && prev_rd == NIL) heads_q[u_l_q[LIW-1:0]] <= next_rd;
      if (cmd_i == bpa_pkg::CMD_P_WR1) heads_q[u_l_q[LIW-1:0]] <= {1'b0, u_p_q};
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      bpa_pkg::CMD_LOAD: begin
        op_q         <= op_i;
        want_q       <= bpa_pkg::want_level(size_kb_i);
        lvl_q        <= bpa_pkg::want_level(size_kb_i);
        pg_q         <= PW'(page_index_i);
        res_status_q <= bpa_pkg::STATUS_OK;
        res_page_q   <= '0;
        res_level_q  <= '0;
      end
      bpa_pkg::CMD_SRCH: begin
        if (head_lvl == NIL && lvl_q <= TOP) lvl_q <= lvl_p1;
      end
      bpa_pkg::CMD_FAIL: res_status_q <= bpa_pkg::STATUS_NO_SPACE;
      bpa_pkg::CMD_S_SET: begin
        a_q   <= head_lvl[PW-1:0];
        b_q   <= head_lvl[PW-1:0] + bit_m1;
        u_l_q <= lvl_q;
        u_p_q <= head_lvl[PW-1:0];
      end
      bpa_pkg::CMD_S_MB: begin
        u_l_q <= lvl_m1;
        u_p_q <= b_q;
      end
      bpa_pkg::CMD_P_WR1: h_q <= head_ul;
      bpa_pkg::CMD_S_PA: begin
        u_p_q <= a_q;
        lvl_q <= lvl_m1;
      end
      bpa_pkg::CMD_G_SET: begin
        u_l_q       <= want_q;
        u_p_q       <= head_want[PW-1:0];
        res_page_q  <= head_want[PW-1:0];
        res_level_q <= want_q;
      end
      bpa_pkg::CMD_F_CHK: begin
        if (is_alloc) begin
          lvl_q <= flvl;
          u_l_q <= flvl;
          u_p_q <= pg_q;
        end else begin
          res_status_q <= bpa_pkg::STATUS_NOT_ALLOC;
        end
      end
      bpa_pkg::CMD_M_CMP: begin
        u_l_q <= lvl_q;
        u_p_q <= lo_pg;
      end
      bpa_pkg::CMD_M_HI: u_p_q <= hi_pg;
      bpa_pkg::CMD_M_MKHI: begin
        u_l_q <= lvl_p1;
        u_p_q <= lo_pg;
        pg_q  <= lo_pg;
        lvl_q <= lvl_p1;
      end
      default: ;
    endcase
  end

  assign status_o        = res_status_q;
  assign granted_page_o  = bpa_pkg::PAGE_W'(res_page_q);
  assign granted_level_o = res_level_q;
endmodule

FILE: hw/rtl/bpa_ctrl.sv
// controller state machine sequencing split, merge and list updates
// depends on bpa_pkg and buddy_page_allocator_unit_defines.svh
`include "buddy_page_allocator_unit_defines.svh"
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  input  bpa_pkg::dp_stat_t stat_i,
  output bpa_pkg::cmd_e     cmd_o
);
  bpa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= bpa_pkg::S_CLEAR;
    else         state_q <= state_d;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bpa_pkg::S_CLEAR: if (stat_i.clr_last) state_d = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE:  if (start) state_d = bpa_pkg::S_DEC;
      bpa_pkg::S_DEC: begin
        if (stat_i.is_free_op)   state_d = bpa_pkg::S_F_RD;
        else if (stat_i.too_big) state_d = bpa_pkg::S_FAIL;
        else                     state_d = bpa_pkg::S_SRCH;
      end
      bpa_pkg::S_SRCH: begin
        if (stat_i.lvl_over)      state_d = bpa_pkg::S_FAIL;
        else if (stat_i.found)    state_d = stat_i.lvl_gt_want ? bpa_pkg::S_S_SET
                                                               : bpa_pkg::S_G_SET;
      end
      bpa_pkg::S_FAIL:  state_d = bpa_pkg::S_RESP;
      bpa_pkg::S_S_SET: state_d = bpa_pkg::S_S_URD;
      bpa_pkg::S_S_URD: state_d = bpa_pkg::S_S_UWR;
      bpa_pkg::S_S_UWR: state_d = bpa_pkg::S_S_MA;
      bpa_pkg::S_S_MA:  state_d = bpa_pkg::S_S_MB;
      bpa_pkg::S_S_MB:  state_d = bpa_pkg::S_S_PB1;
      bpa_pkg::S_S_PB1: state_d = bpa_pkg::S_S_PB2;
      bpa_pkg::S_S_PB2: state_d = bpa_pkg::S_S_PA;
      bpa_pkg::S_S_PA:  state_d = bpa_pkg::S_S_PA1;
      bpa_pkg::S_S_PA1: state_d = bpa_pkg::S_S_PA2;
      bpa_pkg::S_S_PA2: state_d = stat_i.lvl_gt_want ? bpa_pkg::S_S_SET : bpa_pkg::S_G_SET;
      bpa_pkg::S_G_SET: state_d = bpa_pkg::S_G_URD;
      bpa_pkg::S_G_URD: state_d = bpa_pkg::S_G_UWR;
      bpa_pkg::S_G_UWR: state_d = bpa_pkg::S_G_MK;
      bpa_pkg::S_G_MK:  state_d = bpa_pkg::S_RESP;
      bpa_pkg::S_F_RD:  state_d = bpa_pkg::S_F_CHK;
      bpa_pkg::S_F_CHK: state_d = stat_i.is_alloc ? bpa_pkg::S_F_P1 : bpa_pkg::S_RESP;
      bpa_pkg::S_F_P1:  state_d = bpa_pkg::S_F_P2;
      bpa_pkg::S_F_P2:  state_d = bpa_pkg::S_M_CHK;
      bpa_pkg::S_M_CHK: state_d = stat_i.lvl_top ? bpa_pkg::S_RESP : bpa_pkg::S_M_RD;
      bpa_pkg::S_M_RD:  state_d = bpa_pkg::S_M_CMP;
      bpa_pkg::S_M_CMP: state_d = stat_i.bud_free ? bpa_pkg::S_M_LURD : bpa_pkg::S_RESP;
      bpa_pkg::S_M_LURD: state_d = bpa_pkg::S_M_LUWR;
      bpa_pkg::S_M_LUWR: state_d = bpa_pkg::S_M_HI;
      bpa_pkg::S_M_HI:   state_d = bpa_pkg::S_M_HURD;
      bpa_pkg::S_M_HURD: state_d = bpa_pkg::S_M_HUWR;
      bpa_pkg::S_M_HUWR: state_d = bpa_pkg::S_M_MKLO;
      bpa_pkg::S_M_MKLO: state_d = bpa_pkg::S_M_MKHI;
      bpa_pkg::S_M_MKHI: state_d = bpa_pkg::S_M_P1;
      bpa_pkg::S_M_P1:   state_d = bpa_pkg::S_M_P2;
      bpa_pkg::S_M_P2:   state_d = bpa_pkg::S_M_CHK;
      bpa_pkg::S_RESP:   state_d = bpa_pkg::S_IDLE;
      default:           state_d = bpa_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = state_q != bpa_pkg::S_IDLE;
    done_o = state_q == bpa_pkg::S_RESP;
    cmd_o  = bpa_pkg::CMD_NONE;
    case (state_q)
      bpa_pkg::S_CLEAR:  cmd_o = bpa_pkg::CMD_CLEAR;
      bpa_pkg::S_IDLE:   cmd_o = start ? bpa_pkg::CMD_LOAD : bpa_pkg::CMD_NONE;
      bpa_pkg::S_SRCH:   cmd_o = bpa_pkg::CMD_SRCH;
      bpa_pkg::S_FAIL:   cmd_o = bpa_pkg::CMD_FAIL;
      bpa_pkg::S_S_SET:  cmd_o = bpa_pkg::CMD_S_SET;
      bpa_pkg::S_S_URD, bpa_pkg::S_G_URD, bpa_pkg::S_M_LURD, bpa_pkg::S_M_HURD:
        cmd_o = bpa_pkg::CMD_U_RD;
      bpa_pkg::S_S_UWR, bpa_pkg::S_G_UWR, bpa_pkg::S_M_LUWR, bpa_pkg::S_M_HUWR:
        cmd_o = bpa_pkg::CMD_U_WR;
      bpa_pkg::S_S_MA:   cmd_o = bpa_pkg::CMD_S_MA;
      bpa_pkg::S_S_MB:   cmd_o = bpa_pkg::CMD_S_MB;
      bpa_pkg::S_S_PB1, bpa_pkg::S_S_PA1, bpa_pkg::S_F_P1, bpa_pkg::S_M_P1:
        cmd_o = bpa_pkg::CMD_P_WR1;
      bpa_pkg::S_S_PB2, bpa_pkg::S_S_PA2, bpa_pkg::S_F_P2, bpa_pkg::S_M_P2:
        cmd_o = bpa_pkg::CMD_P_WR2;
      bpa_pkg::S_S_PA:   cmd_o = bpa_pkg::CMD_S_PA;
      bpa_pkg::S_G_SET:  cmd_o = bpa_pkg::CMD_G_SET;
      bpa_pkg::S_G_MK:   cmd_o = bpa_pkg::CMD_G_MK;
      bpa_pkg::S_F_RD:   cmd_o = bpa_pkg::CMD_F_RD;
      bpa_pkg::S_F_CHK:  cmd_o = bpa_pkg::CMD_F_CHK;
      bpa_pkg::S_M_RD:   cmd_o = bpa_pkg::CMD_M_RD;
      bpa_pkg::S_M_CMP:  cmd_o = bpa_pkg::CMD_M_CMP;
      bpa_pkg::S_M_HI:   cmd_o = bpa_pkg::CMD_M_HI;
      bpa_pkg::S_M_MKLO: cmd_o = bpa_pkg::CMD_M_MKLO;
      bpa_pkg::S_M_MKHI: cmd_o = bpa_pkg::CMD_M_MKHI;
      default:           cmd_o = bpa_pkg::CMD_NONE;
    endcase
  end

  `BPA_ASSERT(a_done_then_idle, done_o |=> !busy)
  `BPA_ASSERT(a_accept_then_busy, (start && !busy) |=> (busy && !done_o))
  `BPA_ASSERT(a_done_while_busy, done_o |-> busy)
  `BPA_ASSERT_NEVER(a_write_when_idle, !busy && cmd_o != bpa_pkg::CMD_NONE
                    && cmd_o != bpa_pkg::CMD_LOAD)
endmodule

FILE: hw/rtl/buddy_page_allocator_unit.sv
// buddy page allocator, one transaction at a time; alloc searches upward for a free level
// and splits it down to the wanted level, failing when none is free or the size is too big;
// free reports a page not allocated, else merges it with its free buddy up to the top;
// the next start is taken the cycle after done_o; the single ported mark and link memories
// are walked one level at a time; the receiver cannot stall results
// reset: one free top-level block; a clearing pass over all 2^PAGE_COUNT_LOG2 pages, busy high
module buddy_page_allocator_unit #(
  parameter int PAGE_COUNT_LOG2 = bpa_pkg::PAGE_COUNT_LOG2_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [bpa_pkg::SIZE_W-1:0]    size_kb_i,
  input  logic [bpa_pkg::PAGE_W-1:0]    page_index_i,
  output logic                          done_o,
  output logic [bpa_pkg::STATUS_W-1:0]  status_o,
  output logic [bpa_pkg::PAGE_W-1:0]    granted_page_o,
  output logic [bpa_pkg::LEVEL_W-1:0]   granted_level_o
);
  // command and status between sequencer and datapath
  bpa_pkg::cmd_e     cmd;
  bpa_pkg::dp_stat_t stat;

  // sequencer: clearing pass, free level search, split and merge walks
  bpa_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .done_o,
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // datapath: marks, orders, free list links, heads, result registers
  bpa_dp #(.PAGE_COUNT_LOG2(PAGE_COUNT_LOG2)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i           (cmd),
    .op_i,
    .size_kb_i,
    .page_index_i,
    .stat_o          (stat),
    .status_o,
    .granted_page_o,
    .granted_level_o
  );
endmodule
